@@ rtl/pswd_pkg.sv @@
package pswd_pkg;

	localparam int TableDepth = 1024;
	localparam int PortsPerSource = 64;
	localparam int SlotW = $clog2(TableDepth);
	localparam int PortIdxW = $clog2(PortsPerSource);
	localparam int UsedW = SlotW + 1;
	localparam int CountW = 7;

	localparam logic [15:0] WindowReset = 16'd30;
	localparam logic [6:0] ThresholdReset = 7'd10;

	localparam logic [0:0] RegWindow = 1'd0;
	localparam logic [0:0] RegThreshold = 1'd1;

	typedef struct packed {
		logic start;
		logic addr_clr;
		logic addr_inc;
		logic port_clr;
		logic port_inc;
		logic latch_entry;
		logic wr_new;
		logic wr_restart;
		logic wr_port;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic addr_done;
		logic addr_hit;
		logic port_done;
		logic port_hit;
		logic table_full;
		logic in_window;
		logic can_add;
	} status_t;

endpackage

@@ rtl/pswd_datapath.sv @@
module pswd_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [31:0]          in_addr,
	input  logic [15:0]          in_port,
	input  logic [31:0]          in_now,
	input  logic [15:0]          window_seconds,
	input  logic [6:0]           alert_threshold,
	input  pswd_pkg::cmd_t       cmd,
	output pswd_pkg::status_t    status,
	output logic [31:0]          res_data
);
	localparam int SlotW = pswd_pkg::SlotW;
	localparam int PW = pswd_pkg::PortIdxW;
	localparam int UsedW = pswd_pkg::UsedW;

	logic [31:0] addr_mem [pswd_pkg::TableDepth];
	logic [31:0] start_mem [pswd_pkg::TableDepth];
	logic [6:0] count_mem [pswd_pkg::TableDepth];
	logic [15:0] port_mem [pswd_pkg::TableDepth * pswd_pkg::PortsPerSource];

	logic [31:0] addr_q, now_q, addr_rd_q, start_rd_q;
	logic [15:0] port_q, port_rd_q;
	logic [6:0] count_rd_q;
	logic [UsedW-1:0] used_q, ai_q;
	logic [6:0] pi_q;
	logic [SlotW-1:0] slot_q;
	logic [SlotW-1:0] ai_idx;
	logic [SlotW+PW-1:0] prd_idx, pwr_idx, pnew_idx;
	logic [31:0] elapsed;
	logic [6:0] cnt_new;
	logic [15:0] el_sat;
	logic rd_valid_q;
	logic prd_valid_q;
	logic seen_q;

	assign ai_idx = ai_q[SlotW-1:0];
	assign prd_idx = {slot_q, pi_q[PW-1:0]};
	assign pwr_idx = {slot_q, count_rd_q[PW-1:0]};
	assign pnew_idx = {used_q[SlotW-1:0], {PW{1'b0}}};
	assign elapsed = now_q - start_rd_q;
	assign el_sat = (elapsed > 32'hFFFF) ? 16'hFFFF : elapsed[15:0];

	// address and port table reads, one entry a cycle, and table writes
	always_ff @(posedge clk) begin
		addr_rd_q <= addr_mem[ai_idx];
		port_rd_q <= port_mem[prd_idx];
		if (cmd.wr_new) begin
			addr_mem[used_q[SlotW-1:0]] <= addr_q;
			port_mem[pnew_idx] <= port_q;
		end
		if (cmd.wr_port)
			port_mem[pwr_idx] <= port_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_entry) begin
			start_rd_q <= start_mem[slot_q];
			count_rd_q <= count_mem[slot_q];
		end
		if (cmd.wr_new) begin
			start_mem[used_q[SlotW-1:0]] <= now_q;
			count_mem[used_q[SlotW-1:0]] <= 7'd1;
		end
		if (cmd.wr_restart) begin
			start_mem[slot_q] <= now_q;
			count_mem[slot_q] <= 7'd0;
		end
		if (cmd.wr_port)
			count_mem[slot_q] <= count_rd_q + 7'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			ai_q <= '0;
			pi_q <= '0;
			seen_q <= 1'b0;
		end else begin
			if (cmd.addr_clr) ai_q <= '0;
			else if (cmd.addr_inc) ai_q <= ai_q + 1'b1;
			if (cmd.port_clr) pi_q <= '0;
			else if (cmd.port_inc) pi_q <= pi_q + 7'd1;
			if (cmd.wr_new) used_q <= used_q + 1'b1;
			// port match stays until the next request
			if (cmd.port_clr) seen_q <= 1'b0;
			else if (prd_valid_q && port_rd_q == port_q) seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			addr_q <= in_addr;
			port_q <= in_port;
			now_q <= in_now;
		end
		if (status.addr_hit)
			slot_q <= ai_q[SlotW-1:0] - 1'b1;
	end

	// addr_hit: previous cycle's read matches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_valid_q <= 1'b0;
		else rd_valid_q <= cmd.addr_inc;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) prd_valid_q <= 1'b0;
		else prd_valid_q <= cmd.port_inc;
	end

	assign status.addr_hit = rd_valid_q && addr_rd_q == addr_q;
	assign status.addr_done = ai_q >= used_q;
	assign status.port_hit = seen_q || (prd_valid_q && port_rd_q == port_q);
	assign status.port_done = pi_q >= count_rd_q || pi_q >= 7'(pswd_pkg::PortsPerSource);
	assign status.table_full = used_q >= UsedW'(pswd_pkg::TableDepth);
	assign status.in_window = elapsed < {16'd0, window_seconds};
	assign status.can_add = count_rd_q < 7'(pswd_pkg::PortsPerSource);

	// result: alert, uniq, elapsed, new, restart, drop
	always_comb begin
		res_data = '0;
		cnt_new = cmd.wr_port ? count_rd_q + 7'd1 : count_rd_q;
		if (cmd.wr_new) begin
			res_data[8:1] = {1'b0, 7'd1};
			res_data[24] = 1'b1;
		end else if (status.table_full && !cmd.wr_restart && !cmd.latch_entry
				&& cmd.finish && status.addr_done && cmd.port_clr) begin
			res_data[26] = 1'b1;
		end else if (cmd.wr_restart) begin
			res_data[25] = 1'b1;
		end else begin
			res_data[7:1] = cnt_new;
			if (cnt_new >= alert_threshold) begin
				res_data[0] = 1'b1;
				res_data[23:8] = el_sat;
			end
		end
	end
endmodule

@@ rtl/pswd_ctrl.sv @@
module pswd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  pswd_pkg::status_t status,
	output pswd_pkg::cmd_t    cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_ASRCH, S_LATCH, S_PSRCH, S_DECIDE
	} state_t;

	state_t state_q;
	logic out_valid_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.start = in_valid;
				cmd.addr_clr = 1'b1;
			end
			S_ASRCH: begin
				cmd.addr_inc = !status.addr_done && !status.addr_hit;
				if (!status.addr_hit && status.addr_done && !cmd.addr_inc) begin
					cmd.finish = !out_valid_q || out_ready;
					cmd.port_clr = 1'b1;
					cmd.wr_new = cmd.finish && !status.table_full;
				end
			end
			S_LATCH: begin
				cmd.latch_entry = 1'b1;
				cmd.port_clr = 1'b1;
			end
			S_PSRCH: begin
				cmd.port_inc = !status.port_done && !status.port_hit;
			end
			S_DECIDE: begin
				cmd.finish = !out_valid_q || out_ready;
				cmd.wr_restart = cmd.finish && !status.in_window;
				cmd.wr_port = cmd.finish && status.in_window && !status.port_hit
					&& status.can_add;
			end
			default: cmd = '0;
		endcase
	end

	logic pend_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_ASRCH;
				S_ASRCH: begin
					if (status.addr_hit) state_q <= S_LATCH;
					else if (cmd.finish) state_q <= S_IDLE;
				end
				S_LATCH: state_q <= S_PSRCH;
				S_PSRCH: begin
					pend_q <= cmd.port_inc;
					if (!cmd.port_inc && !pend_q) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (cmd.finish) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/port_scan_window_detector.sv @@
// a known source goes through address search, entry latch, port search and decide;
// a new source or a full-table drop ends when the search of all used entries is done
// one request at a time; the next is taken in the cycle after the result is registered,
// and a request's time is set by the one-compare-a-cycle searches
// output register lets the next request start while a result waits
// arst_n clears the control, the table fill count and restores both registers
module port_scan_window_detector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata, // source_address, dest_port, now_seconds
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// alert, port_total, elapsed_seconds, new_source, window_restarted, table_full_drop
	output logic [31:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	logic [15:0] window_q;
	logic [6:0] thresh_q;
	pswd_pkg::cmd_t cmd;
	pswd_pkg::status_t status;
	logic [31:0] res;
	logic [31:0] out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= pswd_pkg::WindowReset;
			thresh_q <= pswd_pkg::ThresholdReset;
		end else if (cfg_we) begin
			case (cfg_index)
				pswd_pkg::RegWindow: window_q <= cfg_data;
				pswd_pkg::RegThreshold: thresh_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk)
		if (cmd.finish) out_q <= res;

	assign m_axis_tdata = out_q;

	pswd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.status(status), .cmd(cmd)
	);

	pswd_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_addr(s_axis_tdata[31:0]), .in_port(s_axis_tdata[47:32]),
		.in_now(s_axis_tdata[79:48]),
		.window_seconds(window_q), .alert_threshold(thresh_q),
		.cmd(cmd), .status(status), .res_data(res)
	);
endmodule
